>>> rtl/srpp_pkg.sv
// Shared types and constants for the servo record/playback PWM block.
`timescale 1ns / 1ps

package srpp_pkg;

    // Item opcodes
    localparam logic [1:0] OP_SAMPLE = 2'd0;
    localparam logic [1:0] OP_BUTTON = 2'd1;
    localparam logic [1:0] OP_TICK   = 2'd2;

    // Mode codes as seen on the mode output
    localparam logic [1:0] MODE_MANUAL = 2'd0;
    localparam logic [1:0] MODE_RECORD = 2'd1;
    localparam logic [1:0] MODE_PLAY   = 2'd2;

    // Mode state, one-hot
    typedef enum logic [2:0] {
        ST_MANUAL = 3'b001,
        ST_RECORD = 3'b010,
        ST_PLAY   = 3'b100
    } t_mode;

    // Default store depth
    localparam int SRPP_STORE_DEPTH = 2048;

    // Reset values
    localparam logic [15:0] PERIOD_RESET = 16'd20000;

    // Pulse width limits in microseconds
    localparam logic [10:0] W_MIN    = 11'd1000;
    localparam logic [10:0] W_CENTER = 11'd1500;

    // Sample thresholds: low ramp below LO_LIMIT, high ramp from HI_START
    localparam logic [11:0] MAP_LO_LIMIT = 12'd1948;
    localparam logic [11:0] MAP_HI_START = 12'd2147;

    // Reciprocal multiply for floor(x * 500 / d), exact for x <= d < 2^12
    localparam int MAP_SHIFT  = 24;
    localparam int MAP_K_W    = 23;
    localparam int MAP_Q_W    = 9;
    localparam int MAP_PROD_W = 12 + MAP_K_W;
    localparam longint unsigned MAP_K_LO_L =
        ((64'd500 << MAP_SHIFT) + 64'd1946) / 64'd1947;
    localparam longint unsigned MAP_K_HI_L =
        ((64'd500 << MAP_SHIFT) + 64'd1947) / 64'd1948;
    localparam logic [MAP_K_W-1:0] MAP_K_LO = MAP_K_W'(MAP_K_LO_L);
    localparam logic [MAP_K_W-1:0] MAP_K_HI = MAP_K_W'(MAP_K_HI_L);

endpackage

>>> rtl/servo_record_playback_pwm_top.sv
// Servo pulse recorder/player with sample mapping and microsecond PWM frame counter.
// Flow: a request accepted into the input register then updates the state registers, which
//   hold its result, once the output is free.
// Throughput: one request per cycle while the result is not stalled; the store read port is
//   read every cycle to keep the next playback width ready.
// Reset: synchronous, active low; the store is not swept, a fill count makes never
//   written entries read as zero, so requests are taken right after reset.
`timescale 1ns / 1ps

module servo_record_playback_pwm_top
    import srpp_pkg::*;
#(
    parameter int STORE_DEPTH = SRPP_STORE_DEPTH
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // request channel
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [1:0]  i_opcode,
    input  logic [11:0] i_sample,
    // result channel
    output logic        o_valid,
    input  logic        i_stall,
    output logic        o_servo_level,
    output logic [10:0] o_pulse_width,
    output logic [9:0]  o_dac_value,
    output logic [1:0]  o_mode,
    output logic        o_rec_led,
    // configuration
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [15:0] i_cfg_period_us
);

    localparam int IDX_W  = $clog2(STORE_DEPTH);
    localparam int FILL_W = $clog2(STORE_DEPTH + 1);
    localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(STORE_DEPTH - 1);

    // Handshake and input register
    logic              r_in_valid;
    logic [1:0]        r_op;
    logic [11:0]       r_sample;
    logic              r_out_valid;
    logic              advance;
    logic              proc;

    // State
    logic [15:0]       r_period;
    t_mode             r_mode, n_mode;
    logic [IDX_W-1:0]  r_rec_idx, n_rec_idx;
    logic [IDX_W-1:0]  r_play_idx, n_play_idx;
    logic [FILL_W-1:0] r_fill, n_fill;
    logic [15:0]       r_count, n_count;
    logic [10:0]       r_match, n_match;
    logic [9:0]        r_dac, n_dac;
    logic              r_pin, n_pin;

    // Store
    logic [10:0]       r_store [STORE_DEPTH];
    logic [10:0]       r_rd_data;
    logic              r_rd_hit;
    logic              store_we;
    logic [10:0]       play_width;

    // Mapping
    logic [11:0]           map_num;
    logic [MAP_K_W-1:0]    map_k;
    logic [10:0]           map_base;
    logic [MAP_PROD_W-1:0] map_prod;
    logic [10:0]           map_width;

    // Tick
    logic [16:0]       tick_next;
    logic              tick_wrap;

    // Flow control: output register frees when empty or taken
    assign advance = !r_out_valid || !i_stall;
    assign proc    = r_in_valid && advance;
    assign o_stall = r_in_valid && !advance;
    assign o_valid = r_out_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (!o_stall) begin
                r_in_valid <= i_valid;
            end
            if (advance) begin
                r_out_valid <= r_in_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && !o_stall) begin
            r_op     <= i_opcode;
            r_sample <= i_sample;
        end
    end

    // Configuration register, always ready
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_period <= PERIOD_RESET;
        end else if (i_cfg_valid) begin
            r_period <= i_cfg_period_us;
        end
    end

    // Sample to pulse width: shared reciprocal multiply for both ramps
    always_comb begin
        if (r_sample < MAP_LO_LIMIT) begin
            map_num  = r_sample;
            map_k    = MAP_K_LO;
            map_base = W_MIN;
        end else if (r_sample < MAP_HI_START) begin
            map_num  = '0;
            map_k    = MAP_K_LO;
            map_base = W_CENTER;
        end else begin
            map_num  = r_sample - MAP_HI_START;
            map_k    = MAP_K_HI;
            map_base = W_CENTER;
        end
        map_prod  = MAP_PROD_W'(map_num) * MAP_PROD_W'(map_k);
        map_width = map_base + 11'(map_prod[MAP_SHIFT +: MAP_Q_W]);
    end

    // Frame counter step
    assign tick_next = {1'b0, r_count} + 17'd1;
    assign tick_wrap = tick_next >= {1'b0, r_period};

    // Prefetched playback width; entries at or above the fill count read zero
    assign play_width = r_rd_hit ? r_rd_data : '0;

    // Next state
    always_comb begin
        n_mode     = r_mode;
        n_rec_idx  = r_rec_idx;
        n_play_idx = r_play_idx;
        n_fill     = r_fill;
        n_count    = r_count;
        n_match    = r_match;
        n_dac      = r_dac;
        n_pin      = r_pin;
        store_we   = 1'b0;
        if (proc) begin
            case (r_op)
                OP_SAMPLE: begin
                    if (r_mode != ST_PLAY) begin
                        n_match = map_width;
                        n_dac   = 10'(map_width - W_MIN);
                        if (r_mode == ST_RECORD) begin
                            store_we  = 1'b1;
                            n_rec_idx = (r_rec_idx == IDX_LAST) ? '0 : r_rec_idx + 1'b1;
                            // written entries always form a prefix from zero
                            if (FILL_W'(r_rec_idx) == r_fill) begin
                                n_fill = r_fill + 1'b1;
                            end
                        end
                    end
                end
                OP_BUTTON: begin
                    case (r_mode)
                        ST_MANUAL: begin
                            n_mode    = ST_RECORD;
                            n_rec_idx = '0;
                        end
                        ST_RECORD: begin
                            n_mode     = ST_PLAY;
                            n_play_idx = '0;
                        end
                        ST_PLAY:   n_mode = ST_MANUAL;
                        default:   n_mode = ST_MANUAL;
                    endcase
                end
                OP_TICK: begin
                    if (tick_wrap) begin
                        n_count = '0;
                        n_pin   = 1'b1;
                        if (r_mode == ST_PLAY) begin
                            n_match    = play_width;
                            n_play_idx = (r_play_idx == IDX_LAST) ? '0 : r_play_idx + 1'b1;
                        end
                    end else begin
                        n_count = tick_next[15:0];
                    end
                    if (n_count == 16'(n_match)) begin
                        n_pin = 1'b0;
                    end
                end
                default: ;
            endcase
        end
    end

    // State registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode     <= ST_MANUAL;
            r_rec_idx  <= '0;
            r_play_idx <= '0;
            r_fill     <= '0;
            r_count    <= '0;
            r_match    <= W_CENTER;
            r_dac      <= '0;
            r_pin      <= 1'b0;
            r_rd_hit   <= 1'b0;
        end else begin
            r_mode     <= n_mode;
            r_rec_idx  <= n_rec_idx;
            r_play_idx <= n_play_idx;
            r_fill     <= n_fill;
            r_count    <= n_count;
            r_match    <= n_match;
            r_dac      <= n_dac;
            r_pin      <= n_pin;
            r_rd_hit   <= FILL_W'(n_play_idx) < n_fill;
        end
    end

    // Width store: record writes, read always follows the next playback index
    always_ff @(posedge i_clk) begin
        if (store_we) begin
            r_store[r_rec_idx] <= map_width;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rd_data <= r_store[n_play_idx];
    end

    // Results follow the state registers; they only move when the output is free
    assign o_servo_level = r_pin;
    assign o_pulse_width = r_match;
    assign o_dac_value   = r_dac;
    assign o_rec_led     = (r_mode == ST_RECORD);

    always_comb begin
        case (r_mode)
            ST_MANUAL: o_mode = MODE_MANUAL;
            ST_RECORD: o_mode = MODE_RECORD;
            ST_PLAY:   o_mode = MODE_PLAY;
            default:   o_mode = MODE_MANUAL;
        endcase
    end

endmodule

>>> rtl/srpp_checker.sv
// Port-level checks for the servo record/playback PWM block, bound to the top level.
`timescale 1ns / 1ps

module srpp_checker
    import srpp_pkg::*;
(
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_valid,
    input logic        o_stall,
    input logic        o_valid,
    input logic        i_stall,
    input logic        o_servo_level,
    input logic [10:0] o_pulse_width,
    input logic [9:0]  o_dac_value,
    input logic [1:0]  o_mode,
    input logic        o_rec_led
);

    // A stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_servo_level) && $stable(o_pulse_width)
            && $stable(o_dac_value) && $stable(o_mode))
        else $error("stalled result changed");

    // Requests back up only behind a stalled result
    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> o_valid && i_stall)
        else $error("input stalled while output free");

    // Record LED tracks the record mode
    a_led_mode: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_rec_led == (o_mode == MODE_RECORD)))
        else $error("record LED disagrees with mode");

    // Only the three defined modes appear
    a_mode_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_mode == MODE_MANUAL || o_mode == MODE_RECORD || o_mode == MODE_PLAY))
        else $error("undefined mode code");

endmodule

bind servo_record_playback_pwm_top srpp_checker u_srpp_checker (.*);

>>> tb/srpp_result_checker.sv
// Result checker for the servo record/playback PWM block: predicts every request and compares.
`timescale 1ns / 1ps

module srpp_result_checker
    import srpp_pkg::*;
#(
    parameter int STORE_DEPTH = SRPP_STORE_DEPTH
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // request channel, observed
    input  logic        i_req_valid,
    input  logic        i_req_stall,
    input  logic [1:0]  i_opcode,
    input  logic [11:0] i_sample,
    // result channel, observed
    input  logic        i_res_valid,
    input  logic        i_res_stall,
    input  logic        i_servo_level,
    input  logic [10:0] i_pulse_width,
    input  logic [9:0]  i_dac_value,
    input  logic [1:0]  i_mode,
    input  logic        i_rec_led,
    // configuration channel, observed
    input  logic        i_cfg_valid,
    input  logic        i_cfg_ready,
    input  logic [15:0] i_cfg_period_us,
    // status toward the test top
    output int          o_fail_count,
    output int          o_pending,
    output int          o_checked
);

    // Mapping slopes: 500 us of swing over each ramp
    localparam int unsigned SWING_US = 500;
    localparam int unsigned LO_SPAN  = 1947;
    localparam int unsigned HI_SPAN  = 1948;
    localparam int          SHOW_MAX = 20;

    typedef struct packed {
        logic        servo_level;
        logic [10:0] pulse_width;
        logic [9:0]  dac_value;
        logic [1:0]  mode;
        logic        rec_led;
    } t_servo_out;

    // Predicted block state
    logic [15:0] period_us;
    logic [1:0]  mode_q;
    int unsigned rec_ptr;
    int unsigned play_ptr;
    int unsigned frame_count;
    logic [10:0] match_us;
    logic [9:0]  dac_q;
    logic        pin_q;
    logic [10:0] width_mem [STORE_DEPTH];

    t_servo_out  servo_out_q [$];
    int          fails   = 0;
    int          checked = 0;
    int          shown   = 0;

    // ADC reading to pulse width with centre deadband, exact floor
    function automatic logic [10:0] sample_to_width(input logic [11:0] smp);
        int unsigned v;
        v = smp;
        if (v < MAP_LO_LIMIT)
            return 11'(W_MIN + v * SWING_US / LO_SPAN);
        if (v < MAP_HI_START)
            return W_CENTER;
        return 11'(W_CENTER + (v - MAP_HI_START) * SWING_US / HI_SPAN);
    endfunction

    function automatic void clear_state();
        period_us   = PERIOD_RESET;
        mode_q      = MODE_MANUAL;
        rec_ptr     = 0;
        play_ptr    = 0;
        frame_count = 0;
        match_us    = W_CENTER;
        dac_q       = '0;
        pin_q       = 1'b0;
        foreach (width_mem[k])
            width_mem[k] = '0;
    endfunction

    // Advance the predicted state by one request and return the outputs after it
    function automatic t_servo_out servo_step(input logic [1:0] op, input logic [11:0] smp);
        t_servo_out res;
        logic [10:0] w;
        case (op)
            OP_SAMPLE: begin
                if (mode_q != MODE_PLAY) begin
                    w        = sample_to_width(smp);
                    match_us = w;
                    dac_q    = 10'(w - W_MIN);
                    if (mode_q == MODE_RECORD) begin
                        width_mem[rec_ptr] = w;
                        rec_ptr = (rec_ptr + 1) % STORE_DEPTH;
                    end
                end
            end
            OP_BUTTON: begin
                case (mode_q)
                    MODE_MANUAL: begin
                        mode_q  = MODE_RECORD;
                        rec_ptr = 0;
                    end
                    MODE_RECORD: begin
                        mode_q   = MODE_PLAY;
                        play_ptr = 0;
                    end
                    default: mode_q = MODE_MANUAL;
                endcase
            end
            OP_TICK: begin
                // frame wrap raises the pin; play mode loads the next stored width
                if (frame_count + 1 >= period_us) begin
                    frame_count = 0;
                    pin_q       = 1'b1;
                    if (mode_q == MODE_PLAY) begin
                        match_us = width_mem[play_ptr];
                        play_ptr = (play_ptr + 1) % STORE_DEPTH;
                    end
                end else begin
                    frame_count = frame_count + 1;
                end
                if (frame_count == match_us)
                    pin_q = 1'b0;
            end
            default: ;  // spare opcode leaves everything alone
        endcase
        res.servo_level = pin_q;
        res.pulse_width = match_us;
        res.dac_value   = dac_q;
        res.mode        = mode_q;
        res.rec_led     = (mode_q == MODE_RECORD);
        return res;
    endfunction

    function automatic void compare_field(input string name, input logic [10:0] want,
                                          input logic [10:0] got);
        if (got !== want) begin
            fails++;
            if (shown < SHOW_MAX) begin
                shown++;
                $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
            end
        end
    endfunction

    // Track the three channels at each rising edge
    always @(posedge i_clk) begin
        t_servo_out want;
        if (!i_rst_n) begin
            clear_state();
            servo_out_q.delete();
        end else begin
            if (i_res_valid && !i_res_stall) begin
                if (servo_out_q.size() == 0) begin
                    fails++;
                    if (shown < SHOW_MAX) begin
                        shown++;
                        $display("%0t: result with nothing expected, expected none, actual %0d/%0d",
                                 $time, i_pulse_width, i_mode);
                    end
                end else begin
                    want = servo_out_q.pop_front();
                    checked++;
                    compare_field("servo_level", want.servo_level, i_servo_level);
                    compare_field("pulse_width", want.pulse_width, i_pulse_width);
                    compare_field("dac_value", want.dac_value, i_dac_value);
                    compare_field("mode", want.mode, i_mode);
                    compare_field("rec_led", want.rec_led, i_rec_led);
                end
            end
            if (i_req_valid && !i_req_stall)
                servo_out_q.push_back(servo_step(i_opcode, i_sample));
            if (i_cfg_valid && i_cfg_ready)
                period_us = i_cfg_period_us;
        end
        o_fail_count <= fails;
        o_pending    <= servo_out_q.size();
        o_checked    <= checked;
    end

endmodule

>>> tb/servo_record_playback_pwm_top_test.sv
// Stimulus and verdict for the servo record/playback PWM block, checked by srpp_result_checker.
`timescale 1ns / 1ps

module servo_record_playback_pwm_top_test;
    import srpp_pkg::*;

    localparam logic [1:0] OP_SPARE    = 2'd3;
    localparam int         CYCLE_LIMIT = 400000;
    localparam int         HOLD_CYCLES = 300;
    localparam int         RAND_PHASES = 8;
    localparam int         PHASE_ITEMS = 120;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_valid;
    logic        o_stall;
    logic [1:0]  i_opcode;
    logic [11:0] i_sample;
    logic        o_valid;
    logic        i_stall = 1'b0;
    logic        o_servo_level;
    logic [10:0] o_pulse_width;
    logic [9:0]  o_dac_value;
    logic [1:0]  o_mode;
    logic        o_rec_led;
    logic        i_cfg_valid;
    logic        o_cfg_ready;
    logic [15:0] i_cfg_period_us;

    int          fail_count;
    int          pending;
    int          checked;

    // Idling knobs, stimulus bookkeeping
    int          gap_max;
    int          stall_pct;
    int          burst_left;
    int          hold_asked;
    int          hold_taken = 0;
    int          hold_left  = 0;
    int          cycle_cnt  = 0;
    int          sent;
    int          periods_used;
    logic [1:0]  stim_mode;

    servo_record_playback_pwm_top i_dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .o_stall        (o_stall),
        .i_opcode       (i_opcode),
        .i_sample       (i_sample),
        .o_valid        (o_valid),
        .i_stall        (i_stall),
        .o_servo_level  (o_servo_level),
        .o_pulse_width  (o_pulse_width),
        .o_dac_value    (o_dac_value),
        .o_mode         (o_mode),
        .o_rec_led      (o_rec_led),
        .i_cfg_valid    (i_cfg_valid),
        .o_cfg_ready    (o_cfg_ready),
        .i_cfg_period_us(i_cfg_period_us)
    );

    srpp_result_checker i_checker (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_req_valid    (i_valid),
        .i_req_stall    (o_stall),
        .i_opcode       (i_opcode),
        .i_sample       (i_sample),
        .i_res_valid    (o_valid),
        .i_res_stall    (i_stall),
        .i_servo_level  (o_servo_level),
        .i_pulse_width  (o_pulse_width),
        .i_dac_value    (o_dac_value),
        .i_mode         (o_mode),
        .i_rec_led      (o_rec_led),
        .i_cfg_valid    (i_cfg_valid),
        .i_cfg_ready    (o_cfg_ready),
        .i_cfg_period_us(i_cfg_period_us),
        .o_fail_count   (fail_count),
        .o_pending      (pending),
        .o_checked      (checked)
    );

    // 12 ns clock
    always begin
        i_clk = 1'b0;
        #6;
        i_clk = 1'b1;
        #6;
    end

    // Run limit
    always @(posedge i_clk) begin
        cycle_cnt++;
        if (cycle_cnt > CYCLE_LIMIT) begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    // Result-side stall: random pattern, or a long hold-off when one is asked for
    always @(negedge i_clk) begin
        if (hold_left > 0) begin
            hold_left--;
            i_stall <= 1'b1;
        end else if (hold_asked != hold_taken) begin
            hold_taken++;
            hold_left = HOLD_CYCLES - 1;
            i_stall <= 1'b1;
        end else begin
            i_stall <= ($urandom_range(99) < stall_pct);
        end
    end

    // Offer one request; bursts of random length with random gaps between them
    task automatic send_request(input logic [1:0] op, input logic [11:0] smp);
        int gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 24);
            gap = (gap_max > 0) ? $urandom_range(0, gap_max) : 0;
            repeat (gap) begin
                @(negedge i_clk);
                i_valid  <= 1'b0;
                i_opcode <= 2'($urandom);
                i_sample <= 12'($urandom);
            end
        end
        burst_left--;
        @(negedge i_clk);
        i_valid  <= 1'b1;
        i_opcode <= op;
        i_sample <= smp;
        do @(posedge i_clk); while (o_stall);
        sent++;
        if (op == OP_BUTTON) begin
            case (stim_mode)
                MODE_MANUAL: stim_mode = MODE_RECORD;
                MODE_RECORD: stim_mode = MODE_PLAY;
                default:     stim_mode = MODE_MANUAL;
            endcase
        end
    endtask

    // Stop offering and wait until every predicted result has come back
    task automatic drain();
        @(negedge i_clk);
        i_valid <= 1'b0;
        burst_left = 0;
        while (pending != 0)
            @(negedge i_clk);
    endtask

    task automatic write_period(input logic [15:0] p);
        drain();
        @(negedge i_clk);
        i_cfg_valid     <= 1'b1;
        i_cfg_period_us <= p;
        do @(posedge i_clk); while (!o_cfg_ready);
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
        periods_used++;
    endtask

    task automatic goto_mode(input logic [1:0] m);
        while (stim_mode != m)
            send_request(OP_BUTTON, 12'($urandom));
    endtask

    // Sample values biased toward the ramp ends and deadband borders
    function automatic logic [11:0] pick_sample();
        case ($urandom_range(9))
            0:       return 12'd0;
            1:       return 12'd4095;
            2:       return 12'($urandom_range(1946, 1949));
            3:       return 12'($urandom_range(2145, 2148));
            default: return 12'($urandom);
        endcase
    endfunction

    initial begin
        logic [15:0] phase_period [RAND_PHASES];
        int          r;

        i_rst_n         = 1'b0;
        i_valid         = 1'b0;
        i_opcode        = OP_SAMPLE;
        i_sample        = '0;
        i_cfg_valid     = 1'b0;
        i_cfg_period_us = PERIOD_RESET;
        gap_max         = 2;
        stall_pct       = 20;
        burst_left      = 0;
        hold_asked      = 0;
        sent            = 0;
        periods_used    = 0;
        stim_mode       = MODE_MANUAL;
        phase_period    = '{16'd1, 16'd65535, 16'd5, 16'd17, 16'd40, 16'd3, 16'd12,
                            16'd0};
        phase_period[RAND_PHASES-1] = 16'($urandom_range(2, 30));

        repeat (12) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Mapping edges in manual mode, spare opcode, tick at the reset period
        send_request(OP_SPARE, 12'hFFF);
        send_request(OP_SAMPLE, 12'd0);
        send_request(OP_SAMPLE, 12'd4095);
        send_request(OP_SAMPLE, 12'd1947);
        send_request(OP_SAMPLE, 12'd1948);
        send_request(OP_SAMPLE, 12'd2146);
        send_request(OP_SAMPLE, 12'd2147);
        send_request(OP_TICK, 12'd0);
        // Record three widths, then play: samples ignored
        send_request(OP_BUTTON, 12'd0);
        send_request(OP_SAMPLE, 12'd0);
        send_request(OP_SAMPLE, 12'd4095);
        send_request(OP_SAMPLE, 12'd2000);
        send_request(OP_BUTTON, 12'd0);
        send_request(OP_SAMPLE, 12'd1234);
        send_request(OP_SPARE, 12'd0);
        // Zero period wraps every tick; the fourth entry was never recorded
        write_period(16'd0);
        repeat (5) send_request(OP_TICK, 12'($urandom));
        // Re-entering record resets the write pointer
        send_request(OP_BUTTON, 12'd0);
        send_request(OP_BUTTON, 12'd0);
        send_request(OP_SAMPLE, 12'd4095);
        send_request(OP_BUTTON, 12'd0);
        send_request(OP_TICK, 12'd0);
        send_request(OP_BUTTON, 12'd0);

        // Long frame: count reaches the match value and the pin drops mid-frame
        write_period(16'd1003);
        gap_max   = 0;
        stall_pct = 0;
        goto_mode(MODE_MANUAL);
        send_request(OP_SAMPLE, 12'd0);
        repeat (1010) send_request(OP_TICK, 12'($urandom));

        // Random mix over several periods and idling styles
        for (int ph = 0; ph < RAND_PHASES; ph++) begin
            write_period(phase_period[ph]);
            gap_max   = (ph % 3 == 0) ? 0 : ((ph % 3 == 1) ? 4 : 12);
            stall_pct = (ph % 3 == 0) ? 0 : ((ph % 3 == 1) ? 25 : 60);
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                if (ph == 3 && n == 60)
                    hold_asked++;
                if (ph == 4 && n == 60)
                    drain();
                r = $urandom_range(99);
                if (r < 4)
                    send_request(OP_SPARE, 12'($urandom));
                else if (r < 14)
                    send_request(OP_BUTTON, 12'($urandom));
                else if (r < 50)
                    send_request(OP_SAMPLE, pick_sample());
                else
                    send_request(OP_TICK, 12'($urandom));
            end
        end

        drain();
        repeat (8) @(posedge i_clk);
        $display("Run: %0d requests over %0d period settings, %0d results compared,",
                 sent, periods_used, checked);
        $display("  covering all modes, deadband edges, mid-frame pin drop and long stalls.");
        if (fail_count == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule

>>> files.f
rtl/srpp_pkg.sv
rtl/servo_record_playback_pwm_top.sv
rtl/srpp_checker.sv
tb/srpp_result_checker.sv
tb/servo_record_playback_pwm_top_test.sv
